### hdl/kms_pkg.sv
// shared constants and control types for the key matrix scanner
`timescale 1ns / 1ps

package kms_pkg;

    localparam int ROWS  = 6;
    localparam int COLS  = 14;
    localparam int ROW_W = 3;
    localparam int COL_W = 4;
    localparam int CNT_W = 7;

    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 24;

    localparam logic [ROW_W-1:0] LAST_ROW     = ROW_W'(ROWS - 1);
    localparam logic [CNT_W-1:0] MAX_KEYS_RST = CNT_W'(6);

    typedef struct packed {
        logic load;
        logic emit_key;
        logic emit_ovf;
        logic emit_sum;
        logic last;
        logic finish;
    } kms_cmd_t;

    typedef struct packed {
        logic out_free;
        logic pending;
        logic single_bit;
        logic hit_limit;
        logic scan_ovf;
        logic end_scan;
    } kms_sts_t;

endpackage

### hdl/kms_ctrl.sv
// control state machine that sequences key reports and summaries
`timescale 1ns / 1ps

module kms_ctrl
    import kms_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  kms_sts_t sts,
    output kms_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WORK = 1'b1;

    logic state_reg;
    logic state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_WORK;
                end
            end
            ST_WORK: begin
                if (sts.scan_ovf) begin
                    cmd.finish = 1'b1;
                end else if (sts.out_free) begin
                    if (sts.pending) begin
                        if (sts.hit_limit) begin
                            cmd.emit_ovf = 1'b1;
                            cmd.last     = 1'b1;
                            cmd.finish   = 1'b1;
                        end else begin
                            cmd.emit_key = 1'b1;
                            if (sts.single_bit && !sts.end_scan) begin
                                cmd.last   = 1'b1;
                                cmd.finish = 1'b1;
                            end
                        end
                    end else begin
                        if (sts.end_scan) begin
                            cmd.emit_sum = 1'b1;
                            cmd.last     = 1'b1;
                        end
                        cmd.finish = 1'b1;
                    end
                end
                if (cmd.finish) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### hdl/kms_dp.sv
// datapath: row and count state, column walker and output register
`timescale 1ns / 1ps

module kms_dp
    import kms_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [CNT_W-1:0]    cfg_wdata,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tuser,
    output logic                m_tlast,
    input  kms_cmd_t            cmd,
    output kms_sts_t            sts
);

    logic [CNT_W-1:0] max_reg;
    logic [COLS-1:0]  bits_reg;
    logic [ROW_W-1:0] row_reg;
    logic [CNT_W-1:0] count_reg;
    logic             ovf_reg;

    logic             m_valid_reg;
    logic             o_sum_reg;
    logic [ROW_W-1:0] o_row_reg;
    logic [COL_W-1:0] o_col_reg;
    logic [CNT_W-1:0] o_cnt_reg;
    logic             o_ovf_reg;
    logic [ROW_W-1:0] o_nrow_reg;
    logic             o_last_reg;

    logic [COLS-1:0]  bits_rest;
    logic [COL_W-1:0] low_col;
    logic [CNT_W-1:0] count_inc;
    logic [ROW_W-1:0] nrow;
    logic             end_scan;
    logic             emit;

    always_comb begin
        low_col = '0;
        for (int i = COLS - 1; i >= 0; i--) begin
            if (bits_reg[i]) begin
                low_col = COL_W'(i);
            end
        end
    end

    assign bits_rest = bits_reg & (bits_reg - 1'b1);
    assign count_inc = count_reg + 1'b1;
    assign end_scan  = (row_reg >= LAST_ROW);
    assign nrow      = end_scan ? '0 : row_reg + 1'b1;
    assign emit      = cmd.emit_key | cmd.emit_ovf | cmd.emit_sum;

    assign sts.out_free   = !m_valid_reg || m_tready;
    assign sts.pending    = |bits_reg;
    assign sts.single_bit = ~|bits_rest;
    assign sts.hit_limit  = (count_inc > max_reg);
    assign sts.scan_ovf   = ovf_reg;
    assign sts.end_scan   = end_scan;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg   <= MAX_KEYS_RST;
            row_reg   <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                max_reg <= cfg_wdata;
            end
            if (cmd.load) begin
                if (s_tuser) begin
                    row_reg   <= '0;
                    count_reg <= '0;
                    ovf_reg   <= 1'b0;
                end
            end else begin
                if (cmd.emit_key || cmd.emit_ovf) begin
                    count_reg <= count_inc;
                end
                if (cmd.emit_ovf) begin
                    ovf_reg <= 1'b1;
                end
                if (cmd.finish) begin
                    if (end_scan) begin
                        row_reg   <= '0;
                        count_reg <= '0;
                        ovf_reg   <= 1'b0;
                    end else begin
                        row_reg <= nrow;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            bits_reg <= s_tdata[COLS-1:0];
        end else if (cmd.emit_key) begin
            bits_reg <= bits_rest;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            o_sum_reg  <= ~cmd.emit_key;
            o_row_reg  <= cmd.emit_key ? row_reg : '0;
            o_col_reg  <= cmd.emit_key ? low_col : '0;
            o_ovf_reg  <= cmd.emit_ovf;
            o_nrow_reg <= nrow;
            o_last_reg <= cmd.last;
            if (cmd.emit_ovf) begin
                o_cnt_reg <= max_reg + 1'b1;
            end else if (cmd.emit_key) begin
                o_cnt_reg <= count_inc;
            end else begin
                o_cnt_reg <= count_reg;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = o_sum_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {6'b0, o_nrow_reg, o_ovf_reg, o_cnt_reg, o_col_reg, o_row_reg};

endmodule

### hdl/key_matrix_scanner_unit.sv
// top level of the key matrix scanner: controller plus datapath
//
// channel  dir  ports                               contents
// s_       in   s_tvalid s_tready s_tdata s_tuser   one column sample per row
// m_       out  m_tvalid m_tready m_tdata m_tuser   key reports and scan summaries
//                m_tlast
// cfg_     in   cfg_we cfg_wdata                    max_keys register
//
// an accepted sample is loaded first, then its result beats (key reports plus
// any summary) follow. the single output register emits one result a cycle
// while it is free; a sample without results emits none.
// reset clears row, key count and overflow flag and sets max_keys to 6.
// a low m_tready holds the column walk while a beat waits; the next sample is
// taken while the last beat of the previous one still waits in the output register.
`timescale 1ns / 1ps

module key_matrix_scanner_unit
    import kms_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [CNT_W-1:0]    cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // column_bits[13:0], zero pad
    input  logic                s_tuser,   // restart
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // key_row, key_col, key_count, overflow, next_row, pad
    output logic                m_tuser,   // is_summary
    output logic                m_tlast
);

    kms_cmd_t cmd;
    kms_sts_t sts;

    kms_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    kms_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

### tb/tb_key_matrix_scanner_unit.sv
// self-checking testbench for key_matrix_scanner_unit with a scan-tracking scoreboard
`timescale 1ns / 1ps

module tb_key_matrix_scanner_unit;
    import kms_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_SAMPLES  = 47;
    localparam int SHOWN_ERRORS   = 10;

    class scan_tracker;
        typedef struct {
            bit             summ;
            bit [ROW_W-1:0] row;
            bit [COL_W-1:0] col;
            bit [CNT_W-1:0] cnt;
            bit             ovf;
            bit [ROW_W-1:0] nrow;
            bit             last;
        } key_report_t;

        bit [ROW_W-1:0] scan_row;
        bit [CNT_W-1:0] key_total;
        bit             scan_ovf;
        bit [CNT_W-1:0] max_keys;
        key_report_t    expected_reports[$];
        int             mismatches;

        function new();
            scan_row   = '0;
            key_total  = '0;
            scan_ovf   = 1'b0;
            max_keys   = MAX_KEYS_RST;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function void note_sample(bit [COLS-1:0] bits, bit restart);
            key_report_t    fresh[$];
            key_report_t    rpt;
            bit [ROW_W-1:0] row;
            bit [ROW_W-1:0] nrow;
            bit             end_scan;
            if (restart) begin
                scan_row  = '0;
                key_total = '0;
                scan_ovf  = 1'b0;
            end
            row      = scan_row;
            end_scan = (row >= LAST_ROW);
            nrow     = end_scan ? '0 : row + 1'b1;
            if (!scan_ovf) begin
                for (int c = 0; c < COLS; c++) begin
                    if (!bits[c]) continue;
                    key_total = key_total + 1'b1;
                    rpt = '{summ: 1'b0, row: row, col: COL_W'(c), cnt: key_total,
                            ovf: 1'b0, nrow: nrow, last: 1'b0};
                    if (key_total > max_keys) begin
                        rpt = '{summ: 1'b1, row: '0, col: '0, cnt: max_keys + 1'b1,
                                ovf: 1'b1, nrow: nrow, last: 1'b0};
                        fresh.push_back(rpt);
                        scan_ovf = 1'b1;
                        break;
                    end
                    fresh.push_back(rpt);
                end
                if (end_scan && !scan_ovf) begin
                    rpt = '{summ: 1'b1, row: '0, col: '0, cnt: key_total,
                            ovf: 1'b0, nrow: nrow, last: 1'b0};
                    fresh.push_back(rpt);
                end
            end
            if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
            foreach (fresh[i]) expected_reports.push_back(fresh[i]);
            if (end_scan) begin
                scan_row  = '0;
                key_total = '0;
                scan_ovf  = 1'b0;
            end else begin
                scan_row = nrow;
            end
        endfunction

        function void check_report(logic summ, logic [M_DATA_W-1:0] data, logic last);
            key_report_t exp_rpt;
            if (expected_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display("unexpected beat: summ=%0d data=%h last=%0d", summ, data, last);
                return;
            end
            exp_rpt = expected_reports.pop_front();
            if (summ !== exp_rpt.summ || data[2:0] !== exp_rpt.row
                    || data[6:3] !== exp_rpt.col || data[13:7] !== exp_rpt.cnt
                    || data[14] !== exp_rpt.ovf || data[17:15] !== exp_rpt.nrow
                    || last !== exp_rpt.last) begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS) begin
                    $display("mismatch: exp summ=%0d row=%0d col=%0d cnt=%0d ovf=%0d %s",
                             exp_rpt.summ, exp_rpt.row, exp_rpt.col, exp_rpt.cnt,
                             exp_rpt.ovf, "");
                    $display("          exp nrow=%0d last=%0d", exp_rpt.nrow, exp_rpt.last);
                    $display("          got summ=%0d row=%0d col=%0d cnt=%0d ovf=%0d",
                             summ, data[2:0], data[6:3], data[13:7], data[14]);
                    $display("          got nrow=%0d last=%0d", data[17:15], last);
                end
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [CNT_W-1:0]    cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;   // column_bits[13:0], zero pad
    logic                s_tuser   = 1'b0; // restart
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;   // key_row, key_col, key_count, overflow, next_row, pad
    logic                m_tuser;   // is_summary
    logic                m_tlast;

    int          s_idle_pct = 18;
    int          r_idle_pct = 81;
    int          quiet_cycles = 0;
    scan_tracker tracker;

    key_matrix_scanner_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= r_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tracker.check_report(m_tuser, m_tdata, m_tlast);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_key_matrix_scanner_unit NOT OK");
            $finish;
        end
    end

    task automatic send_sample(input logic [COLS-1:0] bits, input logic restart);
        while ($urandom_range(99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(bits);
        s_tuser  <= restart;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.note_sample(bits, restart);
        @(negedge aclk);
    endtask

    task automatic drain_reports();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_max_keys(input logic [CNT_W-1:0] value);
        drain_reports();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        tracker.max_keys = value;
    endtask

    task automatic send_random_sample();
        logic [COLS-1:0] bits;
        logic            restart;
        case ($urandom_range(9))
            0, 1, 2: bits = '0;
            3, 4:    bits = COLS'(1) << $urandom_range(COLS - 1);
            5, 6, 7: bits = COLS'($urandom & $urandom & $urandom);
            8:       bits = COLS'($urandom);
            default: bits = '1;
        endcase
        // mostly whole scans, with restarts now and then in mid-scan
        if (tracker.scan_row == '0) begin
            restart = 1'($urandom_range(1));
        end else begin
            restart = ($urandom_range(99) < 6);
        end
        send_sample(bits, restart);
    endtask

    initial begin
        logic [CNT_W-1:0] phase_max[RANDOM_PHASES];
        tracker = new();
        phase_max[0] = CNT_W'(3);
        phase_max[1] = CNT_W'(127);
        phase_max[2] = CNT_W'($urandom_range(84));
        phase_max[3] = CNT_W'(84);
        phase_max[4] = CNT_W'(1);
        phase_max[5] = CNT_W'($urandom_range(30, 5));

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // reset max_keys: single keys, edge columns, normal summary
        send_sample(14'h0000, 1'b1);
        send_sample(14'h0001, 1'b0);
        send_sample(14'h2000, 1'b0);
        send_sample(14'h0000, 1'b0);
        send_sample(14'h0003, 1'b0);
        send_sample(14'h0004, 1'b0);
        // overflow mid-scan, a silent row, restart out of overflow
        send_sample(14'h3fff, 1'b1);
        send_sample(14'h3fff, 1'b0);
        send_sample(14'h0010, 1'b1);
        // overflow on the last row
        send_sample(14'h0000, 1'b0);
        send_sample(14'h0000, 1'b0);
        send_sample(14'h0000, 1'b0);
        send_sample(14'h0000, 1'b0);
        send_sample(14'h3fff, 1'b0);

        // zero limit: first key overflows, empty scan summary
        write_max_keys(CNT_W'(0));
        send_sample(14'h0100, 1'b1);
        send_sample(14'h0000, 1'b1);
        repeat (5) send_sample(14'h0000, 1'b0);

        // full matrix within the limit
        write_max_keys(CNT_W'(84));
        send_sample(14'h3fff, 1'b1);
        repeat (5) send_sample(14'h3fff, 1'b0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 2) begin
                s_idle_pct = 81;
                r_idle_pct = 18;
            end else if (p == 4) begin
                s_idle_pct = 0;
                r_idle_pct = 0;
            end
            write_max_keys(phase_max[p]);
            repeat (PHASE_SAMPLES) send_random_sample();
        end

        drain_reports();
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("tb_key_matrix_scanner_unit OK");
        end else begin
            $display("tb_key_matrix_scanner_unit NOT OK");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/kms_pkg.sv
hdl/kms_ctrl.sv
hdl/kms_dp.sv
hdl/key_matrix_scanner_unit.sv
tb/tb_key_matrix_scanner_unit.sv
